// ===== rtl/nrmq_pkg.sv =====
// ----------------------------------------------------------------------------
// nrmq_pkg
// shared constants and types for the nucleotide range minimum query block
// ----------------------------------------------------------------------------
package nrmq_pkg;

    // sequence capacity and derived widths
    localparam int MAX_LEN  = 4096;
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int LANES    = 4;
    localparam int ENTRY_W  = LANES * CNT_W;
    localparam int POS_W    = 12;
    localparam int IMPACT_W = 3;

    // request codes
    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    // nucleotide codes
    typedef enum logic [1:0] {
        SYM_A = 2'd0,
        SYM_C = 2'd1,
        SYM_G = 2'd2,
        SYM_T = 2'd3
    } t_sym;

    // control states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [ENTRY_W-1:0] t_entry;

endpackage

// ===== rtl/nucleotide_range_min_query.sv =====
// ----------------------------------------------------------------------------
// nucleotide_range_min_query
// prefix-count table of a dna sequence with minimal impact range queries
// ----------------------------------------------------------------------------
// Each item that needs the memory has a prefix memory read step and then
// a step, in S_EXEC, to compare or to write back the next prefix entry;
// o_busy is high in S_EXEC and no new item is taken until it drops. Clear,
// full-table appends and unused codes finish in the accept cycle. A query
// answers with a one-cycle o_valid strobe in the cycle after S_EXEC; the
// receiver cannot stall, so it must take the item then. Entry
// zero of the table is implied, entries 1..MAX_LEN live in the memory and
// are written before they can be read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module nucleotide_range_min_query (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_req_type,
    input  logic [1:0]                    i_symbol,
    input  logic [nrmq_pkg::POS_W-1:0]    i_range_start,
    input  logic [nrmq_pkg::POS_W-1:0]    i_range_end,
    output logic                          o_valid,
    output logic [nrmq_pkg::IMPACT_W-1:0] o_impact,
    output logic                          o_range_error
);

    import nrmq_pkg::*;

    t_state                r_state, n_state;
    t_cnt                  r_len, n_len;
    logic                  r_is_query;
    t_sym                  r_sym;
    logic                  r_lo_zero;
    logic                  r_err;
    logic                  r_valid, n_valid;
    logic [IMPACT_W-1:0]   r_impact, n_impact;
    logic                  r_range_error, n_range_error;

    logic                  accept;
    t_req                  req;
    logic                  start_op;
    logic                  bad_range;
    t_addr                 raddr_a, raddr_b;
    t_entry                rdata_a, rdata_b;
    t_entry                ent_hi, ent_lo, ent_new;
    logic                  mem_we;
    logic [IMPACT_W-1:0]   q_impact;

    assign accept = i_start && (r_state == S_IDLE);
    assign req    = t_req'(i_req_type);
    assign o_busy = (r_state != S_IDLE);

    // range check against the loaded length
    assign bad_range = (i_range_start > i_range_end) ||
                       ({1'b0, i_range_end} >= r_len);

    // memory holds entry e at address e-1; high end is entry end+1
    always_comb begin
        raddr_a = i_range_end;
        if (req == REQ_QUERY) begin
            raddr_b = i_range_start - t_addr'(1);
        end else begin
            raddr_b = t_addr'(r_len - t_cnt'(1));
        end
    end

    // operations that need the memory
    always_comb begin
        start_op = 1'b0;
        unique case (req)
            REQ_APPEND: start_op = (r_len < t_cnt'(MAX_LEN));
            REQ_QUERY:  start_op = 1'b1;
            REQ_CLEAR:  start_op = 1'b0;
            default:    start_op = 1'b0;
        endcase
    end

    // state and capture
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && start_op) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_query <= (req == REQ_QUERY);
            r_sym      <= t_sym'(i_symbol);
            r_err      <= bad_range;
            if (req == REQ_QUERY) begin
                r_lo_zero <= (i_range_start == '0);
            end else begin
                r_lo_zero <= (r_len == '0);
            end
        end
    end

    // prefix memory
    nrmq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LEN)
    ) u_prefix_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (r_len[ADDR_W-1:0]),
        .i_wdata   (ent_new),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // implied zero entry
    assign ent_hi = rdata_a;
    assign ent_lo = r_lo_zero ? '0 : rdata_b;

    // next prefix entry: bump the lane of the appended symbol
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            ent_new[k*CNT_W +: CNT_W] = ent_lo[k*CNT_W +: CNT_W] +
                                        t_cnt'(r_sym == t_sym'(k));
        end
    end

    assign mem_we = (r_state == S_EXEC) && !r_is_query;

    // first lane whose count grew, lowest lane wins
    always_comb begin
        q_impact = '0;
        for (int k = LANES - 1; k >= 0; k--) begin
            if (ent_hi[k*CNT_W +: CNT_W] > ent_lo[k*CNT_W +: CNT_W]) begin
                q_impact = IMPACT_W'(k + 1);
            end
        end
    end

    // length update
    always_comb begin
        n_len = r_len;
        if (accept && (req == REQ_CLEAR)) begin
            n_len = '0;
        end else if (mem_we) begin
            n_len = r_len + t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

    // result item
    always_comb begin
        n_valid       = (r_state == S_EXEC) && r_is_query;
        n_impact      = r_err ? '0 : q_impact;
        n_range_error = r_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            r_impact      <= n_impact;
            r_range_error <= n_range_error;
        end
    end

    assign o_valid       = r_valid;
    assign o_impact      = r_impact;
    assign o_range_error = r_range_error;

endmodule

// ===== rtl/nrmq_ram.sv =====
// ----------------------------------------------------------------------------
// nrmq_ram
// generic memory: one write port, two read ports, registered read data
// ----------------------------------------------------------------------------
module nrmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
